// File: hw/rtl/kep_pkg.sv
// ---------------------------------------------------------------------------
// kep_pkg
// Shared types and constants of the key envelope parser.
// ---------------------------------------------------------------------------
`default_nettype none

package kep_pkg;

  localparam int BYTE_W             = 8;
  localparam int KEY_W              = 4;
  localparam int OFF_W              = 5;
  localparam int LEN_OUT_W          = 32;
  localparam int MAX_VARINT_BYTES_D = 9;
  localparam int LENGTH_BITS_D      = 32;

  localparam logic [BYTE_W-1:0] TYPE_TAG    = 8'h08;
  localparam logic [BYTE_W-1:0] DATA_TAG    = 8'h12;
  localparam logic [KEY_W-1:0]  MAX_KEY_RST = 4'd3;

  typedef enum logic [2:0] {
    PH_TYPE_TAG = 3'd0,
    PH_KEY_TYPE = 3'd1,
    PH_DATA_TAG = 3'd2,
    PH_LENGTH   = 3'd3,
    PH_DATA     = 3'd4
  } kep_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } kep_in_item_t;

  typedef struct packed {
    logic                 status;
    logic [KEY_W-1:0]     key_code;
    logic [OFF_W-1:0]     data_offset;
    logic [LEN_OUT_W-1:0] data_length;
  } kep_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/kep_ifs.sv
// ---------------------------------------------------------------------------
// kep_ifs
// Valid/ready channels of the key envelope parser: byte input, result
// output and configuration write.
// ---------------------------------------------------------------------------
`default_nettype none

interface kep_in_if import kep_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kep_out_if import kep_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [KEY_W-1:0]     key_code;
  logic [OFF_W-1:0]     data_offset;
  logic [LEN_OUT_W-1:0] data_length;
  modport source (output valid, output status, output key_code, output data_offset,
                  output data_length, input ready);
  modport sink   (input valid, input status, input key_code, input data_offset,
                  input data_length, output ready);
endinterface

interface kep_cfg_if import kep_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/kep_in_reg.sv
// ---------------------------------------------------------------------------
// kep_in_reg
// Input register: holds one byte request until the parser consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module kep_in_reg import kep_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         req_valid,
  input  wire kep_in_item_t req_item,
  output logic              req_ready,
  input  wire logic         advance,
  output logic              held_valid,
  output kep_in_item_t      held_item
);

  logic         vld_r;
  logic         vld_nxt;
  kep_in_item_t item_r;

  assign req_ready  = !vld_r || advance;
  assign held_valid = vld_r;
  assign held_item  = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (req_ready) begin
      vld_nxt = req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      item_r <= req_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/kep_core.sv
// ---------------------------------------------------------------------------
// kep_core
// Parser state and the per-byte update: tag checks, LEB128 accumulation,
// range checks and data byte count. Produces the result of a last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module kep_core import kep_pkg::*; #(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_D,
  parameter int LENGTH_BITS      = LENGTH_BITS_D
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire kep_in_item_t     item,
  input  wire logic [KEY_W-1:0] max_key_type,
  output kep_result_t           result
);

  localparam int LB = LENGTH_BITS;
  localparam int CW = $clog2(MAX_VARINT_BYTES + 1);
  localparam int WW = 7 * MAX_VARINT_BYTES + 1;
  localparam int SW = $clog2(WW);

  kep_phase_t       phase_r, phase_nxt;
  logic [LB-1:0]    acc_r, acc_nxt;
  logic             over_r, over_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [LB-1:0]    len_r, len_nxt;
  logic [LB-1:0]    rem_r, rem_nxt;
  logic [OFF_W-1:0] pos_r, pos_nxt;
  logic             err_r, err_nxt;

  logic [6:0]       payload;
  logic [SW-1:0]    shift;
  logic [WW-1:0]    wide;
  logic [LB-1:0]    acc_v;
  logic             over_v;
  logic [CW-1:0]    cnt_v;
  logic             vi_bad;
  logic             vi_done;
  logic             key_big;
  logic             len_zero;
  logic             ok;
  logic [63:0]      len_ext;

  // varint byte datapath
  assign payload  = item.data_byte[6:0];
  assign shift    = SW'(7 * cnt_r);
  assign wide     = WW'(payload) << shift;
  assign acc_v    = acc_r | wide[LB-1:0];
  assign over_v   = over_r | (|wide[WW-1:LB]);
  assign cnt_v    = cnt_r + CW'(1);
  assign vi_done  = !item.data_byte[7];
  // bits above 63, continuation past the byte limit, zero trailing byte
  assign vi_bad   = ((shift == SW'(63)) && (payload > 7'd1)) ||
                    (item.data_byte[7] ? (cnt_v >= CW'(MAX_VARINT_BYTES))
                                       : ((cnt_v > CW'(1)) && (item.data_byte == '0)));
  assign key_big  = over_v || (|acc_v[LB-1:KEY_W]) || (acc_v[KEY_W-1:0] > max_key_type);
  assign len_zero = (acc_v == '0) && !over_v;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    over_nxt  = over_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;

    if (step && !err_r) begin
      unique case (phase_r)
        PH_TYPE_TAG, PH_DATA_TAG: begin
          if (item.data_byte != ((phase_r == PH_TYPE_TAG) ? TYPE_TAG : DATA_TAG)) begin
            err_nxt = 1'b1;
          end else begin
            pos_nxt   = pos_r + OFF_W'(1);
            acc_nxt   = '0;
            over_nxt  = 1'b0;
            cnt_nxt   = '0;
            phase_nxt = (phase_r == PH_TYPE_TAG) ? PH_KEY_TYPE : PH_LENGTH;
          end
        end
        PH_KEY_TYPE, PH_LENGTH: begin
          pos_nxt = pos_r + OFF_W'(1);
          if (vi_bad) begin
            err_nxt = 1'b1;
          end else if (!vi_done) begin
            acc_nxt  = acc_v;
            over_nxt = over_v;
            cnt_nxt  = cnt_v;
          end else if (phase_r == PH_KEY_TYPE) begin
            if (key_big) begin
              err_nxt = 1'b1;
            end else begin
              key_nxt   = acc_v[KEY_W-1:0];
              phase_nxt = PH_DATA_TAG;
            end
          end else begin
            if (len_zero || over_v) begin
              err_nxt = 1'b1;
            end else begin
              len_nxt   = acc_v;
              rem_nxt   = acc_v;
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (rem_r == '0) begin
            err_nxt = 1'b1;            // extra byte
          end else begin
            rem_nxt = rem_r - LB'(1);
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end

    ok      = !err_nxt && (phase_nxt == PH_DATA) && (rem_nxt == '0);
    len_ext = 64'(len_nxt);
    result.status      = !ok;
    result.key_code    = ok ? key_nxt : '0;
    result.data_offset = ok ? pos_nxt : '0;
    result.data_length = ok ? len_ext[LEN_OUT_W-1:0] : '0;

    // start over after the last byte
    if (step && item.last_byte) begin
      phase_nxt = PH_TYPE_TAG;
      acc_nxt   = '0;
      over_nxt  = 1'b0;
      cnt_nxt   = '0;
      key_nxt   = '0;
      len_nxt   = '0;
      rem_nxt   = '0;
      pos_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE_TAG;
      acc_r   <= '0;
      over_r  <= 1'b0;
      cnt_r   <= '0;
      key_r   <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      pos_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      over_r  <= over_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/key_envelope_parser.sv
// ---------------------------------------------------------------------------
// key_envelope_parser
// Checks a key envelope streamed one byte per request and reports status,
// key type, data offset and data length on the final byte.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle while no last byte waits; the parser state is registered.
// Result path: an accepted last byte passes through the input register into the parser,
//   and the result register loads when the parser consumes it.
// Only last-byte requests wait on a full result register.
// Reset: synchronous rst_n clears all handshakes and parser state and sets
//   max_key_type to 3.
`default_nettype none

module key_envelope_parser import kep_pkg::*; #(
  parameter int MAX_VARINT_BYTES = MAX_VARINT_BYTES_D,
  parameter int LENGTH_BITS      = LENGTH_BITS_D
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kep_in_if.sink     in_ch,
  kep_out_if.source  out_ch,
  kep_cfg_if.sink    cfg_ch
);

  logic             max_key_r;
  logic [KEY_W-1:0] max_key_type_r;
  kep_in_item_t     req_item;
  kep_in_item_t     held_item;
  logic             held_valid;
  logic             advance;
  logic             out_free;
  logic             out_vld_r, out_vld_nxt;
  kep_result_t      core_res;
  kep_result_t      res_r;

  assign max_key_r = 1'b1;
  assign cfg_ch.ready = max_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_type_r <= MAX_KEY_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_key_type_r <= cfg_ch.data;
    end
  end

  assign req_item.data_byte = in_ch.data_byte;
  assign req_item.last_byte = in_ch.last_byte;

  assign out_free = !out_vld_r || out_ch.ready;
  assign advance  = held_valid && (!held_item.last_byte || out_free);

  kep_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_ch.valid),
    .req_item   (req_item),
    .req_ready  (in_ch.ready),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  kep_core #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
    .LENGTH_BITS      (LENGTH_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .item         (held_item),
    .max_key_type (max_key_type_r),
    .result       (core_res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (advance && held_item.last_byte) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_item.last_byte) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.key_code    = res_r.key_code;
  assign out_ch.data_offset = res_r.data_offset;
  assign out_ch.data_length = res_r.data_length;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && held_item.last_byte |=> out_vld_r)
    else $error("last byte did not load a result");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.status |->
      (res_r.key_code == '0) && (res_r.data_offset == '0) && (res_r.data_length == '0))
    else $error("malformed result carries nonzero fields");

  a_good_has_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.status |-> (res_r.data_offset >= OFF_W'(4)))
    else $error("valid result with short header");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid && !held_item.last_byte |-> in_ch.ready)
    else $error("non-last byte stalled in input register");

endmodule

`default_nettype wire

// File: sim/tb_key_envelope_parser.sv
// ---------------------------------------------------------------------------
// tb_key_envelope_parser
// Streams key envelopes into the parser one byte request at a time: valid
// and broken header layouts first, then random envelopes with random
// corruption under several max_key_type settings. A local model of the
// parse state predicts each report, which is checked field by field.
// ---------------------------------------------------------------------------
module tb_key_envelope_parser;
  import kep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam logic [63:0] LEN_MAX = (64'd1 << LENGTH_BITS_D) - 64'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kep_in_if  in_ch  ();
  kep_out_if out_ch ();
  kep_cfg_if cfg_ch ();

  key_envelope_parser u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  kep_in_item_t bytes_to_send[$];
  kep_result_t  reports_due[$];
  logic [7:0]   env[$];
  int           bytes_queued = 0;
  int           mismatches = 0;
  logic [3:0]   max_key_now = MAX_KEY_RST;

  // model of the parse state
  kep_phase_t  ph;
  logic [63:0] vint;
  int          vcount;
  logic [3:0]  held_key;
  logic [63:0] held_len;
  logic [63:0] left;
  logic [4:0]  hdr_pos;
  bit          bad;
  logic [3:0]  key_limit;

  kep_in_item_t next_req;
  logic         in_taken;
  int           in_gap = 0, in_burst = 0;
  int           out_stall = 0, out_burst = 0;
  int           idle_cycles;

  // mostly short gaps, some long ones, and now and then a run with none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_parse();
    ph = PH_TYPE_TAG;
    vint = '0;
    vcount = 0;
    held_key = '0;
    held_len = '0;
    left = '0;
    hdr_pos = '0;
    bad = 1'b0;
  endfunction

  // Advances the parse by one byte; returns 1 with the report on a last byte.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output kep_result_t res);
    int          sh;
    logic [63:0] pay;
    bit          done;
    res = '0;
    if (!bad) begin
      case (ph)
        PH_TYPE_TAG, PH_DATA_TAG: begin
          if (b != ((ph == PH_TYPE_TAG) ? TYPE_TAG : DATA_TAG)) begin
            bad = 1'b1;
          end else begin
            hdr_pos = hdr_pos + 5'd1;
            vint = '0;
            vcount = 0;
            if (ph == PH_TYPE_TAG) ph = PH_KEY_TYPE;
            else ph = PH_LENGTH;
          end
        end
        PH_KEY_TYPE, PH_LENGTH: begin
          hdr_pos = hdr_pos + 5'd1;
          sh = 7 * vcount;
          pay = {57'd0, b[6:0]};
          done = 1'b0;
          if (sh > 63 || (sh == 63 && pay > 64'd1)) begin
            bad = 1'b1;
          end else begin
            vint = vint | (pay << sh);
            vcount++;
            if (b[7]) begin
              if (vcount >= MAX_VARINT_BYTES_D) bad = 1'b1;
            end else if (vcount > 1 && b == 8'h00) begin
              bad = 1'b1;  // non-minimal encoding
            end else begin
              done = 1'b1;
            end
          end
          if (done && ph == PH_KEY_TYPE) begin
            if (vint > {60'd0, key_limit}) begin
              bad = 1'b1;
            end else begin
              held_key = vint[3:0];
              ph = PH_DATA_TAG;
            end
          end else if (done) begin
            if (vint == 64'd0 || vint > LEN_MAX) begin
              bad = 1'b1;
            end else begin
              held_len = vint;
              left = vint;
              ph = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (left == 64'd0) bad = 1'b1;
          else left = left - 64'd1;
        end
        default: bad = 1'b1;
      endcase
    end
    if (!last) return 1'b0;
    if (!bad && ph == PH_DATA && left == 64'd0) begin
      res.status = 1'b0;
      res.key_code = held_key;
      res.data_offset = hdr_pos;
      res.data_length = held_len[31:0];
    end else begin
      res.status = 1'b1;
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---- envelope building ----
  function automatic void env_varint(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    do begin
      env.push_back({x > 64'd127, x[6:0]});
      x = x >> 7;
    end while (x != 64'd0);
  endfunction

  function automatic void env_header(input logic [63:0] key, input logic [63:0] len);
    env.delete();
    env.push_back(TYPE_TAG);
    env_varint(key);
    env.push_back(DATA_TAG);
    env_varint(len);
  endfunction

  function automatic void env_fill(input int n);
    repeat (n) env.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void env_send();
    kep_in_item_t it;
    foreach (env[i]) begin
      it.data_byte = env[i];
      it.last_byte = (i == env.size() - 1);
      bytes_to_send.push_back(it);
    end
    bytes_queued += env.size();
    env.delete();
  endfunction

  function automatic void rand_envelope();
    logic [63:0] key, len;
    int          r, n;
    r = $urandom_range(0, 9);
    if (r < 6) key = 64'($urandom_range(0, max_key_now));
    else if (r < 8) key = 64'(max_key_now) + 64'($urandom_range(0, 1));
    else key = 64'($urandom_range(0, 200));
    len = ($urandom_range(0, 99) < 90) ? 64'($urandom_range(1, 16))
                                       : 64'($urandom_range(100, 300));
    env_header(key, len);
    env_fill(int'(len));
    case ($urandom_range(0, 9))
      6: env[$urandom_range(0, env.size() - 1)] = 8'($urandom_range(0, 255));
      7: begin
        n = $urandom_range(1, env.size() - 1);
        repeat (n) void'(env.pop_back());
      end
      8: env_fill($urandom_range(1, 3));
      9: begin
        case ($urandom_range(0, 5))
          0: begin
            env.delete();
            env_fill($urandom_range(1, 10));
          end
          1: begin
            env_header(key, 64'd0);
            env_fill($urandom_range(0, 2));
          end
          2: begin
            env_header(64'($urandom_range(0, max_key_now)),
                       {28'd0, 4'($urandom_range(0, 15)), 32'($urandom)});
            env_fill($urandom_range(1, 4));
          end
          3: begin
            env_header(64'($urandom_range(0, max_key_now)), 64'd1);
            void'(env.pop_back());
            env.push_back(8'h80 | 8'($urandom_range(0, 127)));
            env.push_back(8'h00);
            env_fill($urandom_range(1, 3));
          end
          4: begin
            env_header(64'($urandom_range(0, max_key_now)), 64'd1);
            void'(env.pop_back());
            repeat ($urandom_range(9, 10)) env.push_back(8'h80 | 8'($urandom_range(0, 127)));
            env_fill($urandom_range(1, 3));
          end
          default: begin
            // nine-byte length that terminates properly but is far too large
            env_header(64'($urandom_range(0, max_key_now)), 64'd1);
            void'(env.pop_back());
            repeat (8) env.push_back(8'h80 | 8'($urandom_range(0, 127)));
            env.push_back(8'($urandom_range(1, 127)));
            env_fill($urandom_range(1, 3));
          end
        endcase
      end
      default: ;
    endcase
    env_send();
  endfunction

  task automatic settle(input int extra);
    do @(posedge clk);
    while (bytes_to_send.size() != 0 || in_ch.valid || reports_due.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // ---- byte request driver ----
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the request until it is taken
    end else if (in_gap != 0) begin
      in_gap <= in_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (bytes_to_send.size() != 0) begin
      next_req = bytes_to_send.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= next_req.data_byte;
      in_ch.last_byte <= next_req.last_byte;
      in_gap <= pick_gap(in_burst);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // ---- result backpressure ----
  always @(negedge clk) begin
    if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall <= pick_gap(out_burst);
    end
  end

  // ---- monitor, checker and watchdog ----
  always @(posedge clk) begin
    kep_result_t rep, want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
      key_limit = MAX_KEY_RST;
      clear_parse();
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) key_limit = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.data_byte, in_ch.last_byte, rep)) reports_due.push_back(rep);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected report: expected none, actual %0h/%0h/%0h/%0h",
                   $time, out_ch.status, out_ch.key_code, out_ch.data_offset,
                   out_ch.data_length);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("key_code", 32'(want.key_code), 32'(out_ch.key_code));
          check_field("data_offset", 32'(want.data_offset), 32'(out_ch.data_offset));
          check_field("data_length", want.data_length, out_ch.data_length);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---- stimulus ----
  initial begin
    logic [3:0] plan[6];
    int         target;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed envelopes at the reset key limit
    env = {TYPE_TAG, 8'h00, DATA_TAG, 8'h01, 8'hAA};             env_send();
    env = {TYPE_TAG, 8'h03, DATA_TAG, 8'h02, 8'h00, 8'hFF};      env_send();
    env = {8'h09, 8'h00, DATA_TAG, 8'h01, 8'hAA};                env_send();
    env = {TYPE_TAG, 8'h01, 8'h13, 8'h01, 8'h55};                env_send();
    env = {TYPE_TAG, 8'h04, DATA_TAG, 8'h01, 8'h00};             env_send();
    env = {TYPE_TAG, 8'h80, 8'h00, DATA_TAG, 8'h01, 8'h00};      env_send();
    env = {TYPE_TAG, 8'h81, 8'h01, DATA_TAG, 8'h01, 8'h00};      env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG, 8'h81, 8'h00, 8'h7E};      env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG};
    repeat (9) env.push_back(8'hFF);
    env.push_back(8'h01);                                        env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG};
    repeat (8) env.push_back(8'hFF);
    env.push_back(8'h7F);
    env.push_back(8'hAA);                                        env_send();
    env = {TYPE_TAG, 8'h02, DATA_TAG, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h33};
    env_send();
    env = {TYPE_TAG, 8'h02, DATA_TAG, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h33};
    env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG, 8'h00, 8'h44};             env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG, 8'h01, 8'hAA, 8'hBB};      env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG, 8'h03, 8'hAA, 8'hBB};      env_send();
    env = {TYPE_TAG};                                            env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG};                           env_send();
    env = {TYPE_TAG, 8'h01, DATA_TAG, 8'h82};                    env_send();
    env = {DATA_TAG};                                            env_send();
    env_header(64'd1, 64'd130);
    env_fill(130);                                               env_send();

    plan[0] = 4'd15;
    plan[1] = 4'd0;
    plan[2] = 4'($urandom_range(1, 14));
    plan[3] = 4'($urandom_range(0, 15));
    plan[4] = 4'($urandom_range(0, 15));
    plan[5] = MAX_KEY_RST;
    foreach (plan[p]) begin
      // the limit only changes with the parser drained
      settle(4);
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= plan[p];
      max_key_now = plan[p];
      do @(posedge clk); while (!cfg_ch.ready);
      @(negedge clk) cfg_ch.valid <= 1'b0;
      target = bytes_queued + 200;
      while (bytes_queued < target) rand_envelope();
    end

    settle(10);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/kep_pkg.sv
hw/rtl/kep_ifs.sv
hw/rtl/kep_in_reg.sv
hw/rtl/kep_core.sv
hw/rtl/key_envelope_parser.sv
sim/tb_key_envelope_parser.sv
